@@ hdl/hwd_pkg.sv @@
// ----------------------------------------------------------------------------
// hwd_pkg - shared types and constants of the hand wave detector
// Sample layout, command and register codes, scan unit control group.
// ----------------------------------------------------------------------------
package hwd_pkg;

    localparam int COORD_W    = 16;
    localparam int BONE_W     = 5;
    localparam int GESTURE_W  = 4;

    // More reversals than this mean a wave.
    localparam logic [1:0] REVERSAL_LIMIT = 2'd2;

    // Command carried in tuser.
    localparam logic CMD_ADD_POINT = 1'b0;
    localparam logic CMD_QUERY     = 1'b1;

    // Configuration register index (paddr[3:2]).
    localparam logic [1:0] REG_LEFT_HAND  = 2'd0;
    localparam logic [1:0] REG_RIGHT_HAND = 2'd1;
    localparam logic [1:0] REG_SPINE      = 2'd2;
    localparam logic [1:0] REG_WAVE_CODE  = 2'd3;

    // One window sample: y in the high half, x in the low half.
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } sample_t;

    // Per-beat control of a scan unit.
    typedef struct packed {
        logic clear;   // start of a walk
        logic step;    // a sample sits at the chain tail
        logic in_win;  // that sample is a written window entry
    } scan_ctrl_t;

endpackage

@@ hdl/hwd_cell.sv @@
// ----------------------------------------------------------------------------
// hwd_cell - one sample cell of a window chain
// Holds one sample and loads its neighbor's sample when the chain moves.
// ----------------------------------------------------------------------------
module hwd_cell
    import hwd_pkg::*;
(
    input  logic    aclk,
    input  logic    shift_en,
    input  sample_t d_in,
    output sample_t q
);

    sample_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

endmodule

@@ hdl/hwd_chain.sv @@
// ----------------------------------------------------------------------------
// hwd_chain - window of one hand as a row of sample cells
// Push shifts a new sample into cell 0; rotate feeds the tail back to cell 0.
// ----------------------------------------------------------------------------
module hwd_chain
    import hwd_pkg::*;
#(
    parameter int DEPTH = 60
) (
    input  logic    aclk,
    input  logic    push,
    input  logic    rotate,
    input  sample_t push_data,
    output sample_t tail
);

    sample_t link [DEPTH];
    sample_t head_in;
    logic    shift_en;

    assign shift_en = push | rotate;
    assign head_in  = rotate ? link[DEPTH-1] : push_data;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            hwd_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (head_in),
                .q        (link[i])
            );
        end else begin : g_rest
            hwd_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (link[i-1]),
                .q        (link[i])
            );
        end
    end

    assign tail = link[DEPTH-1];

endmodule

@@ hdl/hwd_scan.sv @@
// ----------------------------------------------------------------------------
// hwd_scan - reversal counter of one hand
// Takes one sample a beat, oldest first, and counts x step sign reversals.
// ----------------------------------------------------------------------------
module hwd_scan
    import hwd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  scan_ctrl_t                ctrl,
    input  sample_t                   sample,
    input  logic signed [COORD_W-1:0] thresh,
    output logic                      wave
);

    logic                      seen_reg;
    logic signed [COORD_W-1:0] last_x_reg;
    logic                      last_pos_reg;
    logic                      last_neg_reg;
    logic [1:0]                rev_reg;

    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W:0]   step_val;
    logic                      used;
    logic                      pos;
    logic                      neg;
    logic                      reversal;

    // The first written sample seeds the previous x.
    assign ref_x    = seen_reg ? last_x_reg : sample.x;
    assign step_val = {ref_x[COORD_W-1], ref_x} - {sample.x[COORD_W-1], sample.x};
    assign pos      = !step_val[COORD_W] && (step_val != '0);
    assign neg      = step_val[COORD_W];
    assign used     = ctrl.step && ctrl.in_win && (sample.y > thresh);
    assign reversal = (neg && last_pos_reg) || (pos && last_neg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            seen_reg     <= 1'b0;
            last_pos_reg <= 1'b0;
            last_neg_reg <= 1'b0;
            rev_reg      <= '0;
        end else begin
            if (ctrl.step && ctrl.in_win) begin
                seen_reg <= 1'b1;
            end
            if (used) begin
                last_pos_reg <= pos;
                last_neg_reg <= neg;
                // saturate: three already means a wave
                if (reversal && rev_reg != 2'd3) begin
                    rev_reg <= rev_reg + 2'd1;
                end
            end
        end
    end

    // Seed from the oldest written sample even when it sits below the spine.
    always_ff @(posedge aclk) begin
        if (ctrl.step && ctrl.in_win && (!seen_reg || used)) begin
            last_x_reg <= sample.x;
        end
    end

    assign wave = rev_reg > REVERSAL_LIMIT;

endmodule

@@ hdl/hand_wave_detector.sv @@
// ----------------------------------------------------------------------------
// hand_wave_detector - skeleton hand wave detector
// Keeps recent hand samples and the spine height, answers wave queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one beat per command. s_tuser = 0 adds a joint point
//   (bone, pos_x, pos_y); s_tuser = 1 asks about gesture_id. Add beats give
//   no result; each query gives exactly one result beat on m_* with
//   wave_seen in m_tdata[0].
//   Each hand window is a row of WINDOW_DEPTH sample cells. A query that asks
//   for the wave code (with a spine sample present) rotates both rows once
//   around, one cell a cycle, feeding each tail cell to its own reversal counter.
//   A matching query is accepted in ST_IDLE, walks the rows in ST_WALK and
//   then loads its result into the output register from ST_DONE; other
//   queries go straight to ST_DONE. Add beats leave the sequencer idle. A new
//   query is taken only once the last one is through; s_tready is low while a query is in work.
//   Stall: a finished result waits in the output register until m_tready;
//   add beats are still taken meanwhile, and a following query is taken and
//   walked, then holds in the sequencer until the output register drains.
//   Reset: windows empty, no spine sample, registers to their defaults
//   (left hand 7, right hand 11, spine 1, wave code 0). Cell contents are not
//   cleared; the fill counts hide unwritten cells.
//   Configuration: APB, registers at byte addresses 0, 4, 8, 12; write only
//   while the block is idle.
// ----------------------------------------------------------------------------
module hand_wave_detector
    import hwd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // bone[4:0], pos_x[20:5], pos_y[36:21], gesture_id[40:37]
    input  logic        s_tuser,   // cmd[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // wave_seen[0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // ------------------------------------------------------------------
    // Input beat fields
    // ------------------------------------------------------------------
    logic                        in_beat;
    logic                        cmd;
    logic [BONE_W-1:0]           bone;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic [GESTURE_W-1:0]        gesture_id;
    sample_t                     new_sample;

    assign cmd        = s_tuser;
    assign bone       = s_tdata[4:0];
    assign pos_x      = s_tdata[20:5];
    assign pos_y      = s_tdata[36:21];
    assign gesture_id = s_tdata[40:37];
    assign new_sample = '{y: pos_y, x: pos_x};
    assign in_beat    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BONE_W-1:0]    left_bone_reg;
    logic [BONE_W-1:0]    right_bone_reg;
    logic [BONE_W-1:0]    spine_bone_reg;
    logic [GESTURE_W-1:0] wave_code_reg;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_bone_reg  <= BONE_W'(7);
            right_bone_reg <= BONE_W'(11);
            spine_bone_reg <= BONE_W'(1);
            wave_code_reg  <= '0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_LEFT_HAND:  left_bone_reg  <= pwdata[BONE_W-1:0];
                REG_RIGHT_HAND: right_bone_reg <= pwdata[BONE_W-1:0];
                REG_SPINE:      spine_bone_reg <= pwdata[BONE_W-1:0];
                REG_WAVE_CODE:  wave_code_reg  <= pwdata[GESTURE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LEFT_HAND:  prdata = {{(32-BONE_W){1'b0}}, left_bone_reg};
            REG_RIGHT_HAND: prdata = {{(32-BONE_W){1'b0}}, right_bone_reg};
            REG_SPINE:      prdata = {{(32-BONE_W){1'b0}}, spine_bone_reg};
            REG_WAVE_CODE:  prdata = {{(32-GESTURE_W){1'b0}}, wave_code_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          walk_cnt_reg, walk_cnt_next;
    logic                      force_zero_reg, force_zero_next;
    logic [CNT_W-1:0]          left_fill_reg;
    logic [CNT_W-1:0]          right_fill_reg;
    logic signed [COORD_W-1:0] spine_y_reg;
    logic                      spine_valid_reg;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic                      wave_reg, wave_next;

    logic    add_beat;
    logic    query_beat;
    logic    push_left;
    logic    push_right;
    logic    rotate;
    logic    walk_last;
    logic    out_free;
    logic    left_wave;
    logic    right_wave;
    logic    left_in_win;
    logic    right_in_win;
    sample_t left_tail;
    sample_t right_tail;
    scan_ctrl_t left_ctrl;
    scan_ctrl_t right_ctrl;

    assign s_tready   = (state_reg == ST_IDLE);
    assign add_beat   = in_beat && (cmd == CMD_ADD_POINT);
    assign query_beat = in_beat && (cmd == CMD_QUERY);
    assign push_left  = add_beat && (bone == left_bone_reg);
    assign push_right = add_beat && (bone == right_bone_reg);
    assign rotate     = (state_reg == ST_WALK);
    assign walk_last  = (walk_cnt_reg == CNT_W'(WINDOW_DEPTH - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        walk_cnt_next   = walk_cnt_reg;
        force_zero_next = force_zero_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        wave_next       = wave_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (query_beat) begin
                    // start a walk only when a wave can be reported at all
                    if (gesture_id == wave_code_reg && spine_valid_reg) begin
                        force_zero_next = 1'b0;
                        walk_cnt_next   = '0;
                        state_next      = ST_WALK;
                    end else begin
                        force_zero_next = 1'b1;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (walk_last) begin
                    walk_cnt_next = '0;
                    state_next    = ST_DONE;
                end else begin
                    walk_cnt_next = walk_cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    wave_next     = !force_zero_reg && (left_wave || right_wave);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            walk_cnt_reg    <= '0;
            force_zero_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            left_fill_reg   <= '0;
            right_fill_reg  <= '0;
            spine_y_reg     <= '0;
            spine_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            walk_cnt_reg   <= walk_cnt_next;
            force_zero_reg <= force_zero_next;
            m_tvalid_reg   <= m_tvalid_next;
            // count up to a full window, then the chain drops its oldest cell
            if (push_left && left_fill_reg != CNT_W'(WINDOW_DEPTH)) begin
                left_fill_reg <= left_fill_reg + CNT_W'(1);
            end
            if (push_right && right_fill_reg != CNT_W'(WINDOW_DEPTH)) begin
                right_fill_reg <= right_fill_reg + CNT_W'(1);
            end
            if (add_beat && bone == spine_bone_reg) begin
                spine_y_reg     <= pos_y;
                spine_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wave_reg <= wave_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, wave_reg};

    // ------------------------------------------------------------------
    // Window chains and scan units
    // ------------------------------------------------------------------
    // Walk beat k sees cell WINDOW_DEPTH-1-k at the tail; that cell holds a
    // written sample when k + fill reaches the depth.
    assign left_in_win  = ({1'b0, walk_cnt_reg} + {1'b0, left_fill_reg})
                          >= (CNT_W+1)'(WINDOW_DEPTH);
    assign right_in_win = ({1'b0, walk_cnt_reg} + {1'b0, right_fill_reg})
                          >= (CNT_W+1)'(WINDOW_DEPTH);
    assign left_ctrl  = '{clear: query_beat, step: rotate, in_win: left_in_win};
    assign right_ctrl = '{clear: query_beat, step: rotate, in_win: right_in_win};

    hwd_chain #(.DEPTH(WINDOW_DEPTH)) u_left_chain (
        .aclk      (aclk),
        .push      (push_left),
        .rotate    (rotate),
        .push_data (new_sample),
        .tail      (left_tail)
    );

    hwd_chain #(.DEPTH(WINDOW_DEPTH)) u_right_chain (
        .aclk      (aclk),
        .push      (push_right),
        .rotate    (rotate),
        .push_data (new_sample),
        .tail      (right_tail)
    );

    hwd_scan u_left_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (left_ctrl),
        .sample  (left_tail),
        .thresh  (spine_y_reg),
        .wave    (left_wave)
    );

    hwd_scan u_right_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (right_ctrl),
        .sample  (right_tail),
        .thresh  (spine_y_reg),
        .wave    (right_wave)
    );

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        left_fill_reg <= CNT_W'(WINDOW_DEPTH) && right_fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window fill count beyond depth");

    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && walk_last) |=> (state_reg == ST_DONE))
        else $error("walk did not end after one full rotation");

    a_wave_needs_spine: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> spine_valid_reg)
        else $error("wave reported without a spine sample");

    a_idle_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_WALK) |-> (walk_cnt_reg == '0))
        else $error("walk counter not cleared outside a walk");
`endif

endmodule

@@ sim/tb_hand_wave_detector.sv @@
// ----------------------------------------------------------------------------
// tb_hand_wave_detector - self-checking bench for the hand wave detector
// Streams add-point and query beats through the block, predicts each query
// answer from its own copy of the hand windows and spine height, and checks
// the result beats in order under random gaps, stalls and register settings.
// ----------------------------------------------------------------------------
module tb_hand_wave_detector
    import hwd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH   = 60;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SEG_ITEMS   = 330;
    localparam int N_SEGS      = 6;
    localparam int HAND_L      = 0;
    localparam int HAND_R      = 1;

    // One input beat, fields as the block sees them.
    typedef struct packed {
        logic                        cmd;
        logic [BONE_W-1:0]           bone;
        logic signed [COORD_W-1:0]   pos_x;
        logic signed [COORD_W-1:0]   pos_y;
        logic [GESTURE_W-1:0]        gesture_id;
    } skel_beat_t;

    bit          aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // bone[4:0], pos_x[20:5], pos_y[36:21], gesture_id[40:37]
    logic        s_tuser  = 1'b0; // cmd[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // wave_seen[0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    hand_wave_detector #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the registers, hand windows and spine.
    // ------------------------------------------------------------------------
    logic [BONE_W-1:0]         cfg_left  = 5'd7;
    logic [BONE_W-1:0]         cfg_right = 5'd11;
    logic [BONE_W-1:0]         cfg_spine = 5'd1;
    logic [GESTURE_W-1:0]      cfg_wave  = 4'd0;

    sample_t                   hand_win  [2][WIN_DEPTH];
    int                        hand_fill [2] = '{0, 0};
    int                        hand_head [2] = '{0, 0};
    logic signed [COORD_W-1:0] spine_y    = '0;
    bit                        spine_seen = 1'b0;

    skel_beat_t beat_fifo[$];     // beats waiting for the driver
    bit         pending_waves[$]; // predicted wave_seen per accepted query
    skel_beat_t cur_beat;
    bit         beat_taken = 1'b0;
    int         n_pushed   = 0;
    int         n_accepted = 0;
    int         n_results  = 0;
    int         n_bad      = 0;
    int         n_cycles   = 0;
    int         tx_idle_pct = 7;
    int         rx_idle_pct = 77;
    int         hold_cycles = 0;

    // Append to a hand window; overwrite the oldest sample once full.
    function automatic void push_sample(int h, sample_t smp);
        if (hand_fill[h] < WIN_DEPTH) begin
            hand_win[h][(hand_head[h] + hand_fill[h]) % WIN_DEPTH] = smp;
            hand_fill[h]++;
        end else begin
            hand_win[h][hand_head[h]] = smp;
            hand_head[h] = (hand_head[h] + 1) % WIN_DEPTH;
        end
    endfunction

    // Walk a window oldest to newest over samples above the spine and count
    // sign reversals of the x step. A zero step still replaces the old step.
    function automatic bit hand_is_waving(int h);
        sample_t smp;
        int      last_x;
        int      last_step;
        int      stp;
        int      revs;
        if (hand_fill[h] == 0)
            return 1'b0;
        last_x    = $signed(hand_win[h][hand_head[h]].x);
        last_step = 0;
        revs      = 0;
        for (int i = 0; i < hand_fill[h]; i++) begin
            smp = hand_win[h][(hand_head[h] + i) % WIN_DEPTH];
            if ($signed(smp.y) > $signed(spine_y)) begin
                stp = last_x - $signed(smp.x);
                if ((stp < 0 && last_step > 0) || (stp > 0 && last_step < 0))
                    revs++;
                last_step = stp;
                last_x    = $signed(smp.x);
            end
        end
        return revs > REVERSAL_LIMIT;
    endfunction

    // Apply one accepted beat; a query queues its predicted answer.
    function automatic void apply_skel_beat(skel_beat_t b);
        sample_t smp;
        bit      seen;
        if (b.cmd == CMD_ADD_POINT) begin
            smp.x = b.pos_x;
            smp.y = b.pos_y;
            // Bone matches are independent: one point may feed several stores.
            if (b.bone == cfg_left)
                push_sample(HAND_L, smp);
            if (b.bone == cfg_right)
                push_sample(HAND_R, smp);
            if (b.bone == cfg_spine) begin
                spine_y    = b.pos_y;
                spine_seen = 1'b1;
            end
        end else begin
            seen = 1'b0;
            if (b.gesture_id == cfg_wave && spine_seen)
                seen = hand_is_waving(HAND_L) || hand_is_waving(HAND_R);
            pending_waves.insert(pending_waves.size(), seen);
        end
    endfunction

    function automatic void push_beat(logic cmd, int bone, int x, int y, int gid);
        skel_beat_t b;
        b.cmd        = cmd;
        b.bone       = BONE_W'(bone);
        b.pos_x      = COORD_W'(x);
        b.pos_y      = COORD_W'(y);
        b.gesture_id = GESTURE_W'(gid);
        beat_fifo.insert(beat_fifo.size(), b);
        n_pushed++;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present beats at the falling edge, hold each until taken.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || beat_taken) begin
            if (beat_fifo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cur_beat = beat_fifo[0];
                beat_fifo.delete(0);
                s_tvalid <= 1'b1;
                s_tuser  <= cur_beat.cmd;
                s_tdata  <= {7'b0, cur_beat.gesture_id, cur_beat.pos_y,
                             cur_beat.pos_x, cur_beat.bone};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    // Predict at the accepting edge so the model sees beats in block order.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            apply_skel_beat(cur_beat);
            beat_taken = 1'b1;
            n_accepted++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off counted down here.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        bit want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_waves.size() == 0) begin
                if (n_bad < 10)
                    $display("result %0d: unexpected beat, wave_seen=%0b",
                             n_results, m_tdata[0]);
                n_bad++;
            end else begin
                want = pending_waves[0];
                pending_waves.delete(0);
                if (m_tdata[0] !== want) begin
                    if (n_bad < 10)
                        $display("result %0d: wave_seen expected %0b got %0b",
                                 n_results, want, m_tdata[0]);
                    n_bad++;
                end
            end
        end
    end

    // Watchdog: bound the run no matter where it hangs.
    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Setup then access phase; the register updates on the access edge.
    task automatic write_reg(logic [1:0] idx, int val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LEFT_HAND:  cfg_left  = BONE_W'(val);
            REG_RIGHT_HAND: cfg_right = BONE_W'(val);
            REG_SPINE:      cfg_spine = BONE_W'(val);
            REG_WAVE_CODE:  cfg_wave  = GESTURE_W'(val);
            default: ;
        endcase
    endtask

    // Drain: all beats taken, all answers back, then let an add settle.
    task automatic wait_idle();
        wait (n_accepted == n_pushed && pending_waves.size() == 0);
        repeat (WIN_DEPTH + 4) @(posedge aclk);
    endtask

    // Mostly hand strokes with random shape, some spine updates, queries and
    // stray bones. Strokes mix ramps, swings and flat runs so that answers
    // come out both ways.
    task automatic gen_segment(int n_items);
        int made;
        int pick;
        int len;
        int shape;
        int bone;
        int x0;
        int amp;
        int stp;
        int per;
        int x;
        int y;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                push_beat(CMD_QUERY, $urandom_range(19), $urandom, $urandom,
                          ($urandom_range(9) < 8) ? int'(cfg_wave) : $urandom_range(15));
                made++;
            end else if (pick < 20) begin
                case ($urandom_range(3))
                    0:       y = $urandom;
                    1:       y = $urandom_range(32767, 16000);
                    default: y = int'($urandom_range(14000)) - 12000;
                endcase
                push_beat(CMD_ADD_POINT, cfg_spine, $urandom, y, $urandom_range(15));
                made++;
            end else if (pick < 25) begin
                push_beat(CMD_ADD_POINT, $urandom_range(19), $urandom, $urandom,
                          $urandom_range(15));
                made++;
            end else begin
                bone  = $urandom_range(1) ? int'(cfg_left) : int'(cfg_right);
                len   = $urandom_range(24, 1);
                shape = $urandom_range(99);
                x0    = int'($urandom_range(32000)) - 16000;
                amp   = $urandom_range(16000, 1);
                stp   = int'($urandom_range(1200)) - 600;
                per   = $urandom_range(8, 2);
                for (int j = 0; j < len && made < n_items; j++) begin
                    if (shape < 15)
                        x = $urandom;
                    else if (shape < 50)
                        x = x0 + j * stp;
                    else if (shape < 75)
                        x = x0 + (((j / per) % 2) ? amp : 0);
                    else
                        x = x0 + (($urandom_range(7) == 0) ? stp : 0);
                    y = ($urandom_range(9) < 8) ? $urandom_range(32767, 4000) : $urandom;
                    push_beat(CMD_ADD_POINT, bone, x, y, $urandom_range(15));
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int seg_left  [N_SEGS];
        int seg_right [N_SEGS];
        int seg_spine [N_SEGS];
        int seg_wave  [N_SEGS];

        seg_left  = '{0, 19, 5, 3, 7, 0};
        seg_right = '{19, 0, 5, 14, 11, 0};
        seg_spine = '{10, 0, 5, 16, 1, 0};
        seg_wave  = '{15, 0, 7, 9, 0, 0};

        // Hold reset, release on a falling edge.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under reset register values.
        // Query before any spine sample and with empty windows.
        push_beat(CMD_QUERY, 0, 0, 0, 0);
        // Left swings at full scale, with one zero step masking a reversal.
        push_beat(CMD_ADD_POINT, 7, -32768, 32767, 0);
        push_beat(CMD_ADD_POINT, 7,  32767, 32767, 0);
        push_beat(CMD_ADD_POINT, 7,  32767, 32767, 0);
        push_beat(CMD_ADD_POINT, 7, -32768, 32767, 15);
        push_beat(CMD_ADD_POINT, 7,  32767, 32767, 0);
        push_beat(CMD_ADD_POINT, 7, -32768, 32767, 0);
        // Left window holds samples but still no spine sample.
        push_beat(CMD_QUERY, 31, -1, -1, 0);
        // Lowest spine: two reversals are not enough.
        push_beat(CMD_ADD_POINT, 1, 32767, -32768, 0);
        push_beat(CMD_QUERY, 0, 0, 0, 0);
        // A third reversal makes a wave; another code still answers no.
        push_beat(CMD_ADD_POINT, 7, 32767, 32767, 0);
        push_beat(CMD_QUERY, 0, 0, 0, 0);
        push_beat(CMD_QUERY, 0, 0, 0, 15);
        // Stray bones are dropped.
        push_beat(CMD_ADD_POINT, 19, -1, -1, 15);
        push_beat(CMD_ADD_POINT, 0, 0, 0, 0);
        // Right swings that sit at the floor and never count.
        push_beat(CMD_ADD_POINT, 11,  100, -32768, 0);
        push_beat(CMD_ADD_POINT, 11, -100, -32768, 0);
        push_beat(CMD_ADD_POINT, 11,  100, -32768, 0);
        push_beat(CMD_ADD_POINT, 11, -100, -32768, 0);
        push_beat(CMD_ADD_POINT, 11,  100, -32768, 0);
        // Highest spine hides every sample.
        push_beat(CMD_ADD_POINT, 1, 0, 32767, 0);
        push_beat(CMD_QUERY, 0, 0, 0, 0);
        // Lower spine brings the left wave back.
        push_beat(CMD_ADD_POINT, 1, 0, -1, 0);
        push_beat(CMD_QUERY, 0, 0, 0, 0);

        // Random part: two segments per gap profile, new registers each time.
        for (int seg = 0; seg < N_SEGS; seg++) begin
            wait_idle();
            if (seg == N_SEGS - 1) begin
                seg_left[seg]  = $urandom_range(19);
                seg_right[seg] = $urandom_range(19);
                seg_spine[seg] = $urandom_range(19);
                seg_wave[seg]  = $urandom_range(15);
            end
            write_reg(REG_LEFT_HAND,  seg_left[seg]);
            write_reg(REG_RIGHT_HAND, seg_right[seg]);
            write_reg(REG_SPINE,      seg_spine[seg]);
            write_reg(REG_WAVE_CODE,  seg_wave[seg]);
            case (seg / 2)
                0: begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 77;
                end
                1: begin
                    tx_idle_pct = 77;
                    rx_idle_pct = 7;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            gen_segment(SEG_ITEMS);
            // Starve the output while beats keep coming so the block backs up.
            if (seg == 4)
                hold_cycles = 500;
        end

        wait_idle();
        n_bad += pending_waves.size();
        if (n_bad == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
